FILE: sv/cvls_pkg.sv
`default_nettype none
package cvls_pkg;

	localparam int STORE_COLUMNS   = 16;
	localparam int STORE_ROWS      = 128;
	localparam int LINES_PER_FRAME = 263;

	localparam int COL_W  = (STORE_COLUMNS > 1) ? $clog2(STORE_COLUMNS) : 1;
	localparam int ROW_W  = $clog2(STORE_ROWS);
	localparam int DEPTH  = STORE_COLUMNS * STORE_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WORD_W = 32;
	localparam int LINE_W = 9;
	localparam int OFS_W  = 12;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	localparam logic [OFS_W-1:0] OFS_SYNC   = 12'd0;
	localparam logic [OFS_W-1:0] OFS_SWAP   = 12'd256;
	localparam logic [OFS_W-1:0] OFS_BURST  = 12'd257;
	localparam logic [OFS_W-1:0] OFS_BLACK  = 12'd550;
	localparam logic [OFS_W-1:0] OFS_PIXELS = 12'd700;

	localparam logic [LINE_W-1:0] LINE_SWAP_FIRST    = 9'd248;
	localparam logic [LINE_W-1:0] LINE_SWAP_LAST     = 9'd250;
	localparam logic [LINE_W-1:0] LINE_NOBURST_FIRST = 9'd246;
	localparam logic [LINE_W-1:0] LINE_NOBURST_LAST  = 9'd253;
	localparam logic [LINE_W-1:0] LINE_VIS_FIRST     = 9'd26;
	localparam logic [LINE_W-1:0] LINE_VIS_LAST      = 9'd224;
	localparam logic [LINE_W-1:0] LINE_ROW_BASE      = 9'd25;
	localparam logic [LINE_W-1:0] LINE_LAST          = LINE_W'(LINES_PER_FRAME);

	typedef enum logic [1:0] {
		KIND_SYNC  = 2'd0,
		KIND_BLACK = 2'd1,
		KIND_BURST = 2'd2,
		KIND_PIXEL = 2'd3
	} kind_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SYNC,
		ST_SWAP,
		ST_BURST,
		ST_BLANK,
		ST_PIX,
		ST_TAIL
	} state_t;

	typedef struct packed {
		logic [4:0]        pad;
		logic [WORD_W-1:0] word;
		logic [6:0]        row;
		logic [3:0]        column;
	} in_data_t;

	typedef struct packed {
		logic [2:0]        pad;
		logic [WORD_W-1:0] word;
		logic [OFS_W-1:0]  start;
		logic [LINE_W-1:0] line;
	} out_data_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage
`default_nettype wire

FILE: sv/cvls_ram.sv
`default_nettype none
module cvls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: sv/cvls_seq.sv
`default_nettype none
module cvls_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  cvls_pkg::opcode_t               opcode,
	input  cvls_pkg::in_data_t              in_d,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output cvls_pkg::out_data_t             out_d,
	output cvls_pkg::kind_t                 out_kind,
	output logic                            out_last,
	output cvls_pkg::ram_req_t              ram_req,
	input  logic [cvls_pkg::WORD_W-1:0]     ram_rdata
);
	import cvls_pkg::*;

	state_t             state_q, state_d;
	logic [LINE_W-1:0]  line_q;
	logic [LINE_W-1:0]  cur_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               m_tvalid_q;
	out_data_t          out_q;
	kind_t              kind_q;
	logic               last_q;

	logic               slot_free;
	logic               tick_acc;
	logic               load;
	logic [OFS_W-1:0]   seg_start;
	kind_t              seg_kind;
	logic [WORD_W-1:0]  seg_word;
	logic               seg_last;
	logic               col_step;
	logic               swap_line;
	logic               burst_line;
	logic               vis_line;
	logic [LINE_W-1:0]  row_diff;
	logic [ROW_W-1:0]   row_now;
	logic [COL_W-1:0]   col_next;
	logic [LINE_W-1:0]  line_inc;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign tick_acc  = s_tvalid && s_tready && (opcode == OP_TICK);

	assign swap_line  = cur_q inside {[LINE_SWAP_FIRST:LINE_SWAP_LAST]};
	assign burst_line = !(cur_q inside {[LINE_NOBURST_FIRST:LINE_NOBURST_LAST]});
	assign vis_line   = cur_q inside {[LINE_VIS_FIRST:LINE_VIS_LAST]};

	// rows never exceed the store on visible lines, so plain truncation suffices
	assign row_diff = line_q - LINE_ROW_BASE;
	assign row_now  = ROW_W'(row_diff >> 1);
	assign col_next = COL_W'(col_q + 1'b1);
	assign line_inc = line_q + 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_acc) state_d = ST_SYNC;
			end
			ST_SYNC: begin
				if (slot_free) state_d = ST_SWAP;
			end
			ST_SWAP: begin
				if (slot_free) begin
					if (burst_line)    state_d = ST_BURST;
					else if (vis_line) state_d = ST_PIX;
					else               state_d = ST_IDLE;
				end
			end
			ST_BURST: begin
				if (slot_free) state_d = ST_BLANK;
			end
			ST_BLANK: begin
				if (slot_free) state_d = vis_line ? ST_PIX : ST_IDLE;
			end
			ST_PIX: begin
				if (slot_free && col_q == COL_W'(STORE_COLUMNS - 1)) state_d = ST_TAIL;
			end
			ST_TAIL: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		load      = 1'b0;
		seg_start = OFS_SYNC;
		seg_kind  = KIND_SYNC;
		seg_word  = '0;
		seg_last  = 1'b0;
		col_step  = 1'b0;
		ram_req   = '0;
		ram_req.waddr = ADDR_W'(32'(in_d.column) * STORE_ROWS + 32'(in_d.row));
		ram_req.wdata = in_d.word;
		ram_req.raddr = ADDR_W'(row_now);
		case (state_q)
			ST_IDLE: begin
				// writes outside the store are dropped
				ram_req.we = s_tvalid && (opcode == OP_WRITE)
					&& (32'(in_d.column) < STORE_COLUMNS) && (32'(in_d.row) < STORE_ROWS);
				// prefetch column 0 of this line's row
				ram_req.re = tick_acc;
			end
			ST_SYNC: begin
				load      = slot_free;
				seg_start = OFS_SYNC;
				seg_kind  = swap_line ? KIND_BLACK : KIND_SYNC;
			end
			ST_SWAP: begin
				load      = slot_free;
				seg_start = OFS_SWAP;
				seg_kind  = swap_line ? KIND_SYNC : KIND_BLACK;
				seg_last  = !burst_line && !vis_line;
			end
			ST_BURST: begin
				load      = slot_free;
				seg_start = OFS_BURST;
				seg_kind  = KIND_BURST;
			end
			ST_BLANK: begin
				load      = slot_free;
				seg_start = OFS_BLACK;
				seg_kind  = KIND_BLACK;
				seg_last  = !vis_line;
			end
			ST_PIX: begin
				load      = slot_free;
				seg_start = OFS_PIXELS;
				seg_kind  = KIND_PIXEL;
				seg_word  = ram_rdata;
				col_step  = slot_free;
				// fetch the next column while this one goes out
				ram_req.re    = slot_free && (col_q != COL_W'(STORE_COLUMNS - 1));
				ram_req.raddr = ADDR_W'(32'(col_next) * STORE_ROWS + 32'(row_q));
			end
			ST_TAIL: begin
				load      = slot_free;
				seg_start = OFS_PIXELS;
				seg_kind  = KIND_BLACK;
				seg_last  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			line_q     <= '0;
			col_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick_acc) begin
				line_q <= (line_inc > LINE_LAST) ? LINE_W'(1) : line_inc;
				col_q  <= '0;
			end else if (col_step) begin
				col_q <= col_next;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			cur_q <= line_q;
			row_q <= row_now;
		end
		if (load) begin
			out_q.pad   <= '0;
			out_q.line  <= cur_q;
			out_q.start <= seg_start;
			out_q.word  <= seg_word;
			kind_q      <= seg_kind;
			last_q      <= seg_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign out_d    = out_q;
	assign out_kind = kind_q;
	assign out_last = last_q;

endmodule
`default_nettype wire

FILE: sv/composite_video_line_sequencer_unit.sv
// Channel   Dir  Handshake          tdata (low bit up)                  tuser / tlast
// s_*       in   s_tvalid/s_tready  store_column, store_row, store_word  opcode
// m_*       out  m_tvalid/m_tready  line_number, segment_start, pixel_word
//                                                                       level_kind / last_segment
//
// A line tick is accepted only while the sequencer is idle, and no new input is
// taken until the line's last segment (2 to 21) is loaded; the single read port of the
// frame store prefetches the next column while the current word is sent.
// Reset clears the sequencer, the line counter and the output valid; the frame
// store is not cleared. A stalled output holds the segment and the sequencer waits.
`default_nettype none
module composite_video_line_sequencer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cvls_pkg::IN_DATA_W-1:0]      s_tdata,  // store_column, store_row, store_word
	input  logic                                s_tuser,  // opcode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cvls_pkg::OUT_DATA_W-1:0]     m_tdata,  // line_number, segment_start, pixel_word
	output logic [1:0]                          m_tuser,  // level_kind
	output logic                                m_tlast
);
	import cvls_pkg::*;

	in_data_t          in_d;
	out_data_t         out_d;
	kind_t             out_kind;
	ram_req_t          ram_req;
	logic [WORD_W-1:0] ram_rdata;
	opcode_t           opcode;

	assign in_d   = in_data_t'(s_tdata);
	assign opcode = opcode_t'(s_tuser);

	cvls_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.opcode    (opcode),
		.in_d      (in_d),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_d     (out_d),
		.out_kind  (out_kind),
		.out_last  (m_tlast),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	cvls_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	assign m_tdata = OUT_DATA_W'(out_d);
	assign m_tuser = 2'(out_kind);

endmodule
`default_nettype wire

FILE: sv/cvls_chk.sv
`default_nettype none
module cvls_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [cvls_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [cvls_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]                      m_tuser,
	input  logic                            m_tlast
);
	import cvls_pkg::*;

	out_data_t od;
	assign od = out_data_t'(m_tdata);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	// a line in flight blocks new input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a line");

	a_pixel_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == 2'(KIND_PIXEL)) |-> (od.start == OFS_PIXELS) && !m_tlast)
		else $error("pixel segment at wrong offset or marked last");

	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != 2'(KIND_PIXEL)) |-> (od.word == '0))
		else $error("nonzero word on a non-pixel segment");

endmodule

bind composite_video_line_sequencer_unit cvls_chk u_chk (.*);
`default_nettype wire

FILE: tb/tb_composite_video_line_sequencer_unit.sv
`default_nettype none
module tb_composite_video_line_sequencer_unit;
	import cvls_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_TICKS = 50;

	typedef struct {
		logic [LINE_W-1:0] line;
		logic [OFS_W-1:0]  start;
		kind_t             kind;
		logic [WORD_W-1:0] word;
		logic              last;
	} segment_t;

	typedef struct packed {
		opcode_t           op;
		logic [3:0]        column;
		logic [6:0]        row;
		logic [WORD_W-1:0] word;
		logic              typed;   // expectation written out below, not predicted
		logic [LINE_W-1:0] tline;
	} stim_row_t;

	// layout of every line outside the visible and vertical blanking regions
	localparam logic [OFS_W-1:0] BLANK_START [4] = '{OFS_SYNC, OFS_SWAP, OFS_BURST, OFS_BLACK};
	localparam kind_t BLANK_KIND [4] = '{KIND_SYNC, KIND_BLACK, KIND_BURST, KIND_BLACK};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	composite_video_line_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [LINE_W-1:0] line_now = '0;
	logic [WORD_W-1:0] pixel_store [STORE_COLUMNS][STORE_ROWS];
	bit                stored [STORE_COLUMNS][STORE_ROWS];
	bit                frame_wrapped = 1'b0;

	segment_t segments_due [$];

	int send_idle_pct = 18;
	int recv_idle_pct = 47;
	int mismatches    = 0;
	int segments_seen = 0;
	int writes_sent   = 0;
	int ticks_sent    = 0;
	int cycles        = 0;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch #%0d: %s got 0x%0h, expected 0x%0h (segment %0d)",
			mismatches + 1, what, got, want, segments_seen);
		mismatches++;
	endtask

	task automatic push_segment(input logic [OFS_W-1:0] start, input kind_t kind,
			input logic [WORD_W-1:0] word);
		segment_t seg;
		seg.line  = line_now;
		seg.start = start;
		seg.kind  = kind;
		seg.word  = word;
		seg.last  = 1'b0;
		segments_due.push_back(seg);
	endtask

	function automatic bit is_visible(input logic [LINE_W-1:0] line);
		return line >= LINE_VIS_FIRST && line <= LINE_VIS_LAST;
	endfunction

	// segments of the line held in line_now, then step the counter
	task automatic trace_line(input bit typed);
		logic [ROW_W-1:0] row;
		int               i;
		if (typed) begin
			for (i = 0; i < 4; i++)
				push_segment(BLANK_START[i], BLANK_KIND[i], '0);
		end else begin
			if (line_now >= LINE_SWAP_FIRST && line_now <= LINE_SWAP_LAST) begin
				push_segment(OFS_SYNC, KIND_BLACK, '0);
				push_segment(OFS_SWAP, KIND_SYNC, '0);
			end else begin
				push_segment(OFS_SYNC, KIND_SYNC, '0);
				push_segment(OFS_SWAP, KIND_BLACK, '0);
			end
			if (line_now < LINE_NOBURST_FIRST || line_now > LINE_NOBURST_LAST) begin
				push_segment(OFS_BURST, KIND_BURST, '0);
				push_segment(OFS_BLACK, KIND_BLACK, '0);
			end
			if (is_visible(line_now)) begin
				row = ROW_W'((line_now - LINE_ROW_BASE) >> 1);
				for (i = 0; i < STORE_COLUMNS; i++)
					push_segment(OFS_PIXELS, KIND_PIXEL, pixel_store[i][row]);
				push_segment(OFS_PIXELS, KIND_BLACK, '0);
			end
		end
		segments_due[segments_due.size() - 1].last = 1'b1;
		if (line_now >= LINE_LAST) begin
			line_now = LINE_W'(1);
			frame_wrapped = 1'b1;
		end else begin
			line_now = line_now + 1'b1;
		end
	endtask

	task automatic send_item(input stim_row_t item);
		in_data_t payload;
		payload.pad    = '0;
		payload.word   = item.word;
		payload.row    = item.row;
		payload.column = item.column;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= payload;
		s_tuser  <= item.op;
		do @(posedge clk); while (!s_tready);
		// transaction taken at this edge
		if (item.op == OP_WRITE) begin
			pixel_store[item.column][item.row] = item.word;
			stored[item.column][item.row] = 1'b1;
			writes_sent++;
		end else begin
			if (item.typed && item.tline !== line_now)
				$display("note: typed line %0d differs from counter %0d", item.tline, line_now);
			trace_line(item.typed);
			ticks_sent++;
		end
	endtask

	function automatic stim_row_t random_write(input logic [3:0] column,
			input logic [6:0] row);
		stim_row_t item;
		item.op     = OP_WRITE;
		item.column = column;
		item.row    = row;
		item.word   = $urandom;
		item.typed  = 1'b0;
		item.tline  = '0;
		return item;
	endfunction

	// output side
	always @(posedge clk) begin
		out_data_t got;
		segment_t  want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (segments_due.size() == 0) begin
				flag_mismatch("unexpected segment, line_number", 64'(got.line), 64'h0);
			end else begin
				want = segments_due.pop_front();
				if (got.line !== want.line)
					flag_mismatch("line_number", 64'(got.line), 64'(want.line));
				if (got.start !== want.start)
					flag_mismatch("segment_start", 64'(got.start), 64'(want.start));
				if (m_tuser !== want.kind)
					flag_mismatch("level_kind", 64'(m_tuser), 64'(want.kind));
				if (got.word !== want.word)
					flag_mismatch("pixel_word", 64'(got.word), 64'(want.word));
				if (m_tlast !== want.last)
					flag_mismatch("last_segment", 64'(m_tlast), 64'(want.last));
			end
			segments_seen++;
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d segments outstanding",
				cycles, segments_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t plan [10];
		stim_row_t item;
		int        i;
		int        t;
		int        c;
		logic [ROW_W-1:0] fill_row;

		plan = '{
			'{OP_WRITE, 4'd0,  7'd0,   32'h0000_0000, 1'b1, 9'd0},
			'{OP_WRITE, 4'd15, 7'd127, 32'hFFFF_FFFF, 1'b1, 9'd0},
			'{OP_WRITE, 4'd15, 7'd0,   32'h8000_0001, 1'b1, 9'd0},
			'{OP_WRITE, 4'd0,  7'd127, 32'h7FFF_FFFE, 1'b1, 9'd0},
			'{OP_TICK,  4'd15, 7'd127, 32'hFFFF_FFFF, 1'b1, 9'd0},  // line zero after reset
			'{OP_TICK,  4'd0,  7'd0,   32'h0000_0000, 1'b1, 9'd1},
			'{OP_WRITE, 4'd5,  7'd64,  32'h1234_5678, 1'b1, 9'd0},
			'{OP_TICK,  4'd10, 7'd85,  32'h5A5A_A5A5, 1'b1, 9'd2},
			'{OP_WRITE, 4'd0,  7'd0,   32'hDEAD_BEEF, 1'b1, 9'd0},  // overwrite
			'{OP_TICK,  4'd7,  7'd42,  32'hC3C3_3C3C, 1'b0, 9'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 10; i++)
			send_item(plan[i]);

		// hold off until the pipeline has drained
		s_tvalid <= 1'b0;
		while (segments_due.size() != 0) @(posedge clk);
		@(posedge clk);

		for (t = 0; t < RANDOM_TICKS; t++) begin
			if (t == RANDOM_TICKS / 3) begin
				send_idle_pct = 47;
				recv_idle_pct = 18;
			end else if (t == 2 * RANDOM_TICKS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			while ($urandom_range(99) < 30)
				send_item(random_write(4'($urandom_range(15)), 7'($urandom_range(127))));
			// a visible line reads a whole store row: write what is still missing
			if (is_visible(line_now)) begin
				fill_row = ROW_W'((line_now - LINE_ROW_BASE) >> 1);
				for (c = 0; c < STORE_COLUMNS; c++)
					if (!stored[c][fill_row])
						send_item(random_write(4'(c), 7'(fill_row)));
			end
			item = random_write(4'($urandom_range(15)), 7'($urandom_range(127)));
			item.op = OP_TICK;
			send_item(item);
		end

		s_tvalid <= 1'b0;
		while (segments_due.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("covered %0d store writes and %0d line ticks, %0d segments checked",
			writes_sent, ticks_sent, segments_seen);
		$display("line counter %s the end of the frame; %0d mismatches",
			frame_wrapped ? "wrapped past" : "did not reach", mismatches);
		if (mismatches == 0 && segments_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
